@@ hw/rtl/dra_pkg.sv @@
// Shared types, constants and saturation helpers for the damped resonator
// amplitude tracker. No dependencies.
package dra_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int ACC_W     = 49;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP   = 8'd0,
        CFG_DAMPING     = 8'd1,
        CFG_STIFFNESS   = 8'd2,
        CFG_AMP_LIMIT   = 8'd3
    } t_cfg_idx;

    localparam logic [31:0] TIME_STEP_RST = 32'd97391;
    localparam logic [30:0] AMP_LIMIT_RST = 31'd6553600;

    localparam logic REQ_FORCE = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FDT,
        S_DMP,
        S_STF,
        S_VEL,
        S_VDT,
        S_POS,
        S_CLR
    } t_state;

    typedef enum logic [1:0] {
        MUL_FORCE_DT,
        MUL_VEL_DMP,
        MUL_POS_STF,
        MUL_VEL_DT
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_init;
        logic     acc_sub;
        logic     vel_wr;
        logic     commit;
        logic     clr;
    } t_seq;

    typedef struct packed {
        logic [30:0] amp;
        logic        rising;
        logic        peak;
        logic        overflow;
    } t_trk;

    function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (!v[ACC_W-1] && (|v[ACC_W-2:31])) begin
            r = 32'sh7FFF_FFFF;
        end else if (v[ACC_W-1] && !(&v[ACC_W-2:31])) begin
            r = 32'sh8000_0000;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_33(input logic signed [32:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // magnitude of a non-positive value, clipped to 31 bits
    function automatic logic [30:0] neg_mag(input logic signed [31:0] v);
        logic signed [32:0] m;
        logic [30:0]        r;
        m = -{v[31], v};
        r = m[30:0];
        if (m[31]) begin
            r = 31'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/dra_mul.sv @@
// Shared 32x32 multiplier with operand select and registered product.
// Depends on dra_pkg.
module dra_mul (
    input  logic                i_clk,
    input  logic                i_en,
    input  dra_pkg::t_mul_sel   i_sel,
    input  logic signed [31:0]  i_force,
    input  logic signed [31:0]  i_vel,
    input  logic signed [31:0]  i_pos,
    input  logic        [31:0]  i_time_step,
    input  logic        [31:0]  i_damping,
    input  logic        [30:0]  i_stiffness,
    output logic signed [63:0]  o_prod
);
    import dra_pkg::*;

    logic signed [31:0] w_a;
    logic        [31:0] w_b;
    logic signed [64:0] w_ax;
    logic signed [64:0] w_bx;
    logic signed [64:0] w_p;
    logic signed [63:0] r_prod;

    always_comb begin
        case (i_sel)
            MUL_FORCE_DT: begin
                w_a = i_force;
                w_b = i_time_step;
            end
            MUL_VEL_DMP: begin
                w_a = i_vel;
                w_b = i_damping;
            end
            MUL_POS_STF: begin
                w_a = i_pos;
                w_b = {1'b0, i_stiffness};
            end
            MUL_VEL_DT: begin
                w_a = i_vel;
                w_b = i_time_step;
            end
            default: begin
                w_a = i_vel;
                w_b = i_time_step;
            end
        endcase
    end

    assign w_ax = {{33{w_a[31]}}, w_a};
    assign w_bx = {33'd0, w_b};
    assign w_p  = w_ax * w_bx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_p[63:0];
        end
    end

    assign o_prod = r_prod;

endmodule

@@ hw/rtl/dra_amp.sv @@
// Direction tracking, peak amplitude latch and sticky overflow flag.
// Depends on dra_pkg.
module dra_amp (
    input  logic               i_rising,
    input  logic               i_overflow,
    input  logic signed [31:0] i_pos,
    input  logic signed [31:0] i_np,
    input  logic        [30:0] i_amp,
    input  logic        [30:0] i_limit,
    output dra_pkg::t_trk      o_trk
);
    import dra_pkg::*;

    logic signed [32:0] w_neg_np;
    logic               w_fall;
    logic               w_rise;

    assign w_neg_np = -{i_np[31], i_np};
    assign w_fall   = i_np < i_pos;
    assign w_rise   = i_pos < i_np;

    always_comb begin
        o_trk.amp    = i_amp;
        o_trk.rising = i_rising;
        o_trk.peak   = 1'b0;
        if (i_rising) begin
            if (w_fall) begin
                o_trk.rising = 1'b0;
                o_trk.peak   = 1'b1;
                if (i_np > 32'sd0) begin
                    o_trk.amp = i_pos[30:0];
                end
            end else if ($signed({1'b0, i_amp}) < i_np) begin
                o_trk.amp = i_np[30:0];
            end
        end else begin
            if (w_rise) begin
                o_trk.rising = 1'b1;
                if (i_np < 32'sd0) begin
                    o_trk.amp = neg_mag(i_pos);
                end
            end else if ($signed({2'b00, i_amp}) < w_neg_np) begin
                o_trk.amp = neg_mag(i_np);
            end
        end
        o_trk.overflow = i_overflow | (o_trk.amp > i_limit);
    end

endmodule

@@ hw/rtl/dra_ctrl.sv @@
// Sequencer stepping one transaction through the shared multiplier.
// Depends on dra_pkg.
module dra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  logic          i_out_free,
    output logic          o_in_ready,
    output dra_pkg::t_seq o_seq
);
    import dra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_seq.mul_en  = 1'b0;
        o_seq.mul_sel = MUL_FORCE_DT;
        o_seq.acc_init = 1'b0;
        o_seq.acc_sub = 1'b0;
        o_seq.vel_wr  = 1'b0;
        o_seq.commit  = 1'b0;
        o_seq.clr     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = (i_req_type == REQ_CLEAR) ? S_CLR : S_FDT;
                end
            end
            S_FDT: begin
                o_seq.mul_en  = 1'b1;
                o_seq.mul_sel = MUL_FORCE_DT;
                n_state       = S_DMP;
            end
            S_DMP: begin
                o_seq.acc_init = 1'b1;
                o_seq.mul_en   = 1'b1;
                o_seq.mul_sel  = MUL_VEL_DMP;
                n_state        = S_STF;
            end
            S_STF: begin
                o_seq.acc_sub = 1'b1;
                o_seq.mul_en  = 1'b1;
                o_seq.mul_sel = MUL_POS_STF;
                n_state       = S_VEL;
            end
            S_VEL: begin
                o_seq.vel_wr = 1'b1;
                n_state      = S_VDT;
            end
            S_VDT: begin
                o_seq.mul_en  = 1'b1;
                o_seq.mul_sel = MUL_VEL_DT;
                n_state       = S_POS;
            end
            S_POS: begin
                if (i_out_free) begin
                    o_seq.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_CLR: begin
                if (i_out_free) begin
                    o_seq.clr = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/damped_resonator_amplitude_tracker_top.sv @@
// Force transaction: four dependent products on the single shared multiplier plus
// accumulate steps; the result commits once the output register is free.
// Clear transaction: zeroes position, velocity, amplitude and overflow flag.
// Results sit in an output register, a new transaction is taken while it waits.
// Synchronous active-low reset: motion state, flags, config and output valid to defaults.
module damped_resonator_amplitude_tracker_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic signed [31:0]                i_force_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [31:0]                o_position,
    output logic        [30:0]                o_amplitude,
    output logic                              o_peak_seen,
    output logic                              o_overflow,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import dra_pkg::*;

    logic        [31:0]      r_time_step;
    logic        [31:0]      r_damping;
    logic        [30:0]      r_stiffness;
    logic        [30:0]      r_limit;
    logic signed [31:0]      r_pos;
    logic signed [31:0]      r_vel;
    logic        [30:0]      r_amp;
    logic                    r_rising;
    logic                    r_ovf;
    logic signed [31:0]      r_force;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    logic signed [31:0]      r_o_pos;
    logic        [30:0]      r_o_amp;
    logic                    r_o_peak;
    logic                    r_o_ovf;

    t_seq                    w_seq;
    t_trk                    w_trk;
    logic signed [63:0]      w_prod;
    logic signed [ACC_W-1:0] w_p32;
    logic signed [ACC_W-1:0] w_p16;
    logic signed [ACC_W-1:0] w_vsum;
    logic signed [32:0]      w_psum;
    logic signed [31:0]      w_np;
    logic                    w_out_free;
    logic                    w_in_acc;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RST;
            r_damping   <= '0;
            r_stiffness <= '0;
            r_limit     <= AMP_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                CFG_DAMPING:   r_damping   <= i_cfg_data;
                CFG_STIFFNESS: r_stiffness <= i_cfg_data[30:0];
                CFG_AMP_LIMIT: r_limit     <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    dra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_seq      (w_seq)
    );

    dra_mul u_mul (
        .i_clk       (i_clk),
        .i_en        (w_seq.mul_en),
        .i_sel       (w_seq.mul_sel),
        .i_force     (r_force),
        .i_vel       (r_vel),
        .i_pos       (r_pos),
        .i_time_step (r_time_step),
        .i_damping   (r_damping),
        .i_stiffness (r_stiffness),
        .o_prod      (w_prod)
    );

    // floor-rounded products back in Q16.16
    assign w_p32  = {{(ACC_W-32){w_prod[63]}}, w_prod[63:32]};
    assign w_p16  = {{(ACC_W-48){w_prod[63]}}, w_prod[63:16]};
    assign w_vsum = r_acc - w_p16;
    assign w_psum = {r_pos[31], r_pos} + {w_prod[63], w_prod[63:32]};
    assign w_np   = sat_33(w_psum);

    dra_amp u_amp (
        .i_rising   (r_rising),
        .i_overflow (r_ovf),
        .i_pos      (r_pos),
        .i_np       (w_np),
        .i_amp      (r_amp),
        .i_limit    (r_limit),
        .o_trk      (w_trk)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_force <= i_force_req;
        end
        if (w_seq.acc_init) begin
            r_acc <= {{(ACC_W-32){r_vel[31]}}, r_vel} + w_p32;
        end else if (w_seq.acc_sub) begin
            r_acc <= r_acc - w_p32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_vel    <= '0;
            r_amp    <= '0;
            r_rising <= 1'b0;
            r_ovf    <= 1'b0;
        end else if (w_seq.clr) begin
            r_pos <= '0;
            r_vel <= '0;
            r_amp <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (w_seq.vel_wr) begin
                r_vel <= sat_acc(w_vsum);
            end
            if (w_seq.commit) begin
                r_pos    <= w_np;
                r_amp    <= w_trk.amp;
                r_rising <= w_trk.rising;
                r_ovf    <= w_trk.overflow;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq.commit || w_seq.clr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.clr) begin
            r_o_pos  <= '0;
            r_o_amp  <= '0;
            r_o_peak <= 1'b0;
            r_o_ovf  <= 1'b0;
        end else if (w_seq.commit) begin
            r_o_pos  <= w_np;
            r_o_amp  <= w_trk.amp;
            r_o_peak <= w_trk.peak;
            r_o_ovf  <= w_trk.overflow;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_o_pos;
    assign o_amplitude = r_o_amp;
    assign o_peak_seen = r_o_peak;
    assign o_overflow  = r_o_ovf;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for damped_resonator_amplitude_tracker_top.
// Depends on dra_pkg and the top module; it predicts every result in place.
module testbench;
    import dra_pkg::*;

    localparam int          RUN_LIMIT    = 400000;
    localparam int          SETTLE_WAIT  = 8;
    localparam logic [7:0]  CFG_IDX_NEXT = 8'd4;
    localparam logic [7:0]  CFG_IDX_TOP  = 8'hFF;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] Q_ZERO       = 32'h0000_0000;
    localparam logic [31:0] Q_NEG_LSB    = 32'hFFFF_FFFF;
    localparam logic [31:0] DT_1_64      = 32'h0400_0000;

    typedef struct {
        logic signed [31:0] position;
        logic [30:0]        amplitude;
        logic               peak_seen;
        logic               overflow;
    } t_motion_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_req_type = REQ_FORCE;
    logic signed [31:0] i_force_req = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_position;
    logic [30:0]        o_amplitude;
    logic               o_peak_seen;
    logic               o_overflow;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // predicted resonator state and its coefficients
    logic [31:0]    coef_time_step;
    logic [31:0]    coef_damping;
    logic [30:0]    coef_stiffness;
    logic [30:0]    coef_amp_limit;
    longint         res_pos;
    longint         res_vel;
    longint         res_amp;
    logic           res_rising;
    logic           res_overflow;

    t_motion_result expected_motion[$];
    int             err_count = 0;
    int             cycle_count = 0;
    bit             steady_flow = 1'b0;
    int             stall_cycles = 0;

    damped_resonator_amplitude_tracker_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_force_req (i_force_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_position  (o_position),
        .o_amplitude (o_amplitude),
        .o_peak_seen (o_peak_seen),
        .o_overflow  (o_overflow),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= RUN_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic longint clip_q32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
        if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
        return v;
    endfunction

    function automatic longint clip_mag(input longint v);
        if (v > longint'(Q_MAX)) return longint'(Q_MAX);
        if (v < 0) return 0;
        return v;
    endfunction

    function automatic void reset_resonator();
        coef_time_step = TIME_STEP_RST;
        coef_damping   = '0;
        coef_stiffness = '0;
        coef_amp_limit = AMP_LIMIT_RST;
        res_pos        = 0;
        res_vel        = 0;
        res_amp        = 0;
        res_rising     = 1'b0;
        res_overflow   = 1'b0;
    endfunction

    function automatic void apply_coef(input logic [7:0] idx, input logic [31:0] val);
        case (idx)
            CFG_TIME_STEP: coef_time_step = val;
            CFG_DAMPING:   coef_damping   = val;
            CFG_STIFFNESS: coef_stiffness = val[30:0];
            CFG_AMP_LIMIT: coef_amp_limit = val[30:0];
            default: ;
        endcase
    endfunction

    // semi-implicit Euler step plus turning-point amplitude tracking
    function automatic void advance_resonator(input logic kind, input logic [31:0] frc);
        longint         f_dt;
        longint         damp;
        longint         stiff;
        longint         nv;
        longint         np;
        t_motion_result r;
        r.peak_seen = 1'b0;
        if (kind == REQ_CLEAR) begin
            res_pos      = 0;
            res_vel      = 0;
            res_amp      = 0;
            res_overflow = 1'b0;
        end else begin
            f_dt  = (longint'(signed'(frc)) * longint'(coef_time_step)) >>> 32;
            damp  = (res_vel * longint'(coef_damping)) >>> 32;
            stiff = (res_pos * longint'(coef_stiffness)) >>> 16;
            nv    = clip_q32(res_vel + f_dt - damp - stiff);
            np    = clip_q32(res_pos + ((nv * longint'(coef_time_step)) >>> 32));
            if (res_rising) begin
                if (np < res_pos) begin
                    res_rising  = 1'b0;
                    r.peak_seen = 1'b1;
                    if (np > 0) res_amp = clip_mag(np > res_pos ? np : res_pos);
                end else if (res_amp < np) begin
                    res_amp = clip_mag(np);
                end
            end else begin
                if (res_pos < np) begin
                    res_rising = 1'b1;
                    if (np < 0) res_amp = clip_mag(-(np < res_pos ? np : res_pos));
                end else if (res_amp < -np) begin
                    res_amp = clip_mag(-np);
                end
            end
            res_pos = np;
            res_vel = nv;
            if (res_amp > longint'(coef_amp_limit)) res_overflow = 1'b1;
        end
        r.position  = res_pos[31:0];
        r.amplitude = res_amp[30:0];
        r.overflow  = res_overflow;
        expected_motion.push_back(r);
    endfunction

    task automatic send_item(input logic kind, input logic [31:0] frc);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_force_req <= frc;
        do @(posedge i_clk); while (!o_in_ready);
        advance_resonator(kind, frc);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_coef(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_motion.size() > 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic void pick_item(output logic kind, output logic [31:0] frc);
        int unsigned sel;
        sel  = $urandom_range(99);
        kind = REQ_FORCE;
        frc  = $urandom;
        if (sel < 4) begin
            kind = REQ_CLEAR;
        end else if (sel < 70) begin
            frc = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        end else if (sel < 85) begin
            frc = $urandom;
        end else if (sel < 93) begin
            frc = $urandom_range(1) ? Q_MAX : Q_MIN;
        end else begin
            frc = 32'($urandom_range(0, 32'h100)) - 32'h80;
        end
    endfunction

    task automatic run_motion(input int n, input logic [31:0] dt, input logic [31:0] dmp,
                              input logic [30:0] stf, input logic [30:0] lim);
        logic        kind;
        logic [31:0] frc;
        settle_block();
        write_reg(CFG_TIME_STEP, dt);
        write_reg(CFG_DAMPING, dmp);
        write_reg(CFG_STIFFNESS, {1'($urandom_range(1)), stf});
        write_reg(CFG_AMP_LIMIT, {1'($urandom_range(1)), lim});
        for (int k = 0; k < n; k++) begin
            pick_item(kind, frc);
            send_item(kind, frc);
        end
    endtask

    task automatic test_register_map();
        settle_block();
        write_reg(CFG_IDX_NEXT, Q_ZERO);
        write_reg(CFG_IDX_TOP, Q_ZERO);
        write_reg(CFG_AMP_LIMIT, 32'h8000_0000 | 32'(AMP_LIMIT_RST));
        write_reg(CFG_STIFFNESS, 32'h8000_0000);
        send_item(REQ_FORCE, 32'h0001_0000);
        send_item(REQ_FORCE, Q_ZERO);
    endtask

    task automatic test_saturation_extremes();
        settle_block();
        write_reg(CFG_TIME_STEP, Q_NEG_LSB);
        write_reg(CFG_DAMPING, Q_ZERO);
        send_item(REQ_CLEAR, Q_MAX);
        repeat (3) send_item(REQ_FORCE, Q_MAX);
        repeat (6) send_item(REQ_FORCE, Q_MIN);
        repeat (4) send_item(REQ_FORCE, Q_MAX);
    endtask

    task automatic test_clear_midmotion();
        send_item(REQ_CLEAR, Q_NEG_LSB);
        send_item(REQ_FORCE, Q_ZERO);
        send_item(REQ_FORCE, Q_NEG_LSB);
        send_item(REQ_CLEAR, Q_ZERO);
    endtask

    task automatic test_free_oscillation();
        repeat (3) begin
            run_motion(300, DT_1_64, $urandom_range(0, 32'h0200_0000),
                       31'($urandom_range(20000, 60000)),
                       31'($urandom_range(32'h1_0000, 32'h40_0000)));
        end
    endtask

    task automatic test_extreme_coefficients();
        run_motion(150, Q_NEG_LSB, Q_NEG_LSB, 31'h7FFF_FFFF, 31'h0);
        run_motion(100, Q_ZERO, Q_ZERO, 31'h0, 31'h7FFF_FFFF);
    endtask

    task automatic test_random_coefficients();
        run_motion(300, $urandom, $urandom, 31'($urandom), 31'($urandom));
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        run_motion(250, DT_1_64, $urandom_range(0, 32'h0080_0000),
                   31'($urandom_range(20000, 60000)),
                   31'($urandom_range(32'h1_0000, 32'h20_0000)));
        steady_flow = 1'b0;
    endtask

    task automatic test_output_backpressure();
        logic        kind;
        logic [31:0] frc;
        settle_block();
        steady_flow = 1'b1;
        @(posedge i_clk);
        stall_cycles = 300;
        for (int k = 0; k < 40; k++) begin
            pick_item(kind, frc);
            send_item(kind, frc);
        end
        steady_flow = 1'b0;
    endtask

    // result receiver: random stalls, always ready in steady flow, or a counted hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_cycles > 0) begin
                i_out_ready <= 1'b0;
                stall_cycles--;
            end else if (steady_flow) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 11);
            end
        end
    end

    always @(posedge i_clk) begin
        t_motion_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_motion.size() == 0) begin
                $error("unexpected result transaction: position %0d", o_position);
                err_count++;
            end else begin
                want = expected_motion.pop_front();
                if (o_position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_position);
                    err_count++;
                end
                if (o_amplitude !== want.amplitude) begin
                    $error("amplitude: expected %0d, got %0d", want.amplitude, o_amplitude);
                    err_count++;
                end
                if (o_peak_seen !== want.peak_seen) begin
                    $error("peak_seen: expected %0b, got %0b", want.peak_seen, o_peak_seen);
                    err_count++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, o_overflow);
                    err_count++;
                end
            end
        end
    end

    initial begin
        reset_resonator();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_saturation_extremes();
        test_clear_midmotion();
        test_free_oscillation();
        test_extreme_coefficients();
        test_random_coefficients();
        test_back_to_back();
        test_output_backpressure();
        settle_block();
        if (expected_motion.size() > 0) begin
            $error("%0d result transactions never arrived", expected_motion.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/dra_pkg.sv
hw/rtl/dra_mul.sv
hw/rtl/dra_amp.sv
hw/rtl/dra_ctrl.sv
hw/rtl/damped_resonator_amplitude_tracker_top.sv
verif/testbench.sv
